/* rtl/gapped_column_map_table_macros.svh */
// Assertion macros used by the block that checks itself.
// Both expect a clock named clk and an active-low reset named rst_n in scope.
`ifndef GAPPED_COLUMN_MAP_TABLE_MACROS_SVH
`define GAPPED_COLUMN_MAP_TABLE_MACROS_SVH

// Same-cycle implication.
`define GCMT_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gapped column map table: assertion failed");

// Next-cycle implication.
`define GCMT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gapped column map table: assertion failed");

`endif

/* rtl/gcmt_pkg.sv */
package gcmt_pkg;

    // Table geometry.
    localparam int SITES     = 64;
    localparam int MAX_WIDTH = 20;

    localparam int IDX_W = (SITES > 1) ? $clog2(SITES) : 1;
    localparam int CNT_W = $clog2(SITES + 1);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int TOT_W = $clog2(SITES * MAX_WIDTH + 1);

    // Arithmetic widths.
    localparam int POS_W   = 32;
    localparam int LEN_W   = 16;
    localparam int VALUE_W = 34;
    localparam int LEFT_W  = VALUE_W + 2;
    localparam int SUM_W   = LEFT_W + 1;
    localparam int REQ_W   = 3;
    localparam int STAT_W  = 2;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd0;
    localparam logic [REQ_W-1:0] REQ_ADD   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WIDTH = 3'd2;
    localparam logic [REQ_W-1:0] REQ_COLOF = 3'd3;
    localparam logic [REQ_W-1:0] REQ_POSOF = 3'd4;
    localparam logic [REQ_W-1:0] REQ_COUNT = 3'd5;

    // Status codes.
    localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_IGNORED = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL    = 2'd2;

    // One stored insertion site.
    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [WID_W-1:0] width;
    } site_t;

    // Start of a pass, from the handshake control to the scan unit.
    typedef struct packed {
        logic             start;
        logic [REQ_W-1:0] req;
    } scan_ctrl_t;

    // Scan unit status back to the handshake control.
    typedef struct packed {
        logic             shift;
        logic             finish;
        logic [CNT_W-1:0] count;
    } scan_stat_t;

endpackage

/* rtl/gcmt_cell.sv */
module gcmt_cell
    import gcmt_pkg::*;
(
    input  logic  clk,
    input  logic  shift,
    input  site_t din,
    output site_t dout
);

    site_t site_reg;

    // Take the neighbor's site whenever the chain moves.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            site_reg <= din;
        end
    end

    assign dout = site_reg;

endmodule

/* rtl/gcmt_scan.sv */
module gcmt_scan
    import gcmt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  scan_ctrl_t                ctrl,
    input  logic [POS_W-1:0]          ref_pos,
    input  logic [LEN_W-1:0]          ins_length,
    input  logic signed [VALUE_W-1:0] column_in,
    input  logic [POS_W-1:0]          region_start,
    input  logic [POS_W-1:0]          region_length,
    input  site_t                     head,
    output site_t                     tail,
    output scan_stat_t                stat,
    output logic signed [VALUE_W-1:0] value,
    output logic [STAT_W-1:0]         status
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_STEP = 2'd1;
    localparam logic [1:0] PH_FIN  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    logic [1:0]                phase_reg, phase_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [REQ_W-1:0]          req_reg, req_next;
    logic [POS_W-1:0]          pos_reg, pos_next;
    logic [WID_W-1:0]          wnew_reg, wnew_next;
    logic                      ignore_reg, ignore_next;
    logic                      done_reg, done_next;
    logic                      carrying_reg, carrying_next;
    site_t                     carry_reg, carry_next;
    logic                      ins_reg, ins_next;
    logic                      full_reg, full_next;
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [TOT_W-1:0]          total_reg, total_next;
    logic [WID_W-1:0]          accw_reg, accw_next;
    logic [TOT_W-1:0]          sum_reg, sum_next;
    logic [POS_W-1:0]          pacc_reg, pacc_next;
    logic signed [LEFT_W-1:0]  left_reg, left_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    logic [STAT_W-1:0]         status_reg, status_next;

    logic                      entry_valid;
    logic                      pos_eq;
    logic                      pos_gt;
    logic                      has_room;
    logic signed [LEFT_W-1:0]  diff;
    logic signed [LEFT_W-1:0]  head_w;
    logic signed [SUM_W-1:0]   pos_sum;
    logic [SUM_W-VALUE_W:0]    sum_top;
    logic [WID_W-1:0]          w_clamped;
    site_t                     new_site;

    // Per-entry comparisons against the site at the head of the chain.
    assign entry_valid = CNT_W'(idx_reg) < count_reg;
    assign pos_eq      = head.pos == pos_reg;
    assign pos_gt      = head.pos > pos_reg;
    assign has_room    = count_reg < CNT_W'(SITES);
    assign new_site    = '{pos: pos_reg, width: wnew_reg};

    // Walk step for position of column: distance left past the plain span up to this site.
    assign diff   = left_reg - $signed({{(LEFT_W-POS_W){1'b0}}, head.pos})
                  + $signed({{(LEFT_W-POS_W){1'b0}}, pacc_reg});
    assign head_w = $signed({{(LEFT_W-WID_W){1'b0}}, head.width});

    // Final position before saturation to the value range.
    assign pos_sum = $signed({{(SUM_W-POS_W){1'b0}}, pacc_reg})
                   + $signed({left_reg[LEFT_W-1], left_reg});
    assign sum_top = pos_sum[SUM_W-1:VALUE_W-1];

    assign w_clamped = (ins_length > LEN_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH)
                                                        : ins_length[WID_W-1:0];

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        req_next      = req_reg;
        pos_next      = pos_reg;
        wnew_next     = wnew_reg;
        ignore_next   = ignore_reg;
        done_next     = done_reg;
        carrying_next = carrying_reg;
        carry_next    = carry_reg;
        ins_next      = ins_reg;
        full_next     = full_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        accw_next     = accw_reg;
        sum_next      = sum_reg;
        pacc_next     = pacc_reg;
        left_next     = left_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        tail          = head;

        unique case (phase_reg) inside
            PH_IDLE, PH_DONE:
            begin
                // Latch the request and arm a full rotation of the table; a clear request empties it.
                if (ctrl.start)
                begin
                    phase_next    = PH_STEP;
                    idx_next      = '0;
                    req_next      = ctrl.req;
                    pos_next      = ref_pos;
                    wnew_next     = w_clamped;
                    ignore_next   = (ins_length == '0) || (ref_pos < region_start)
                                  || ((ref_pos - region_start) >= region_length);
                    done_next     = 1'b0;
                    carrying_next = 1'b0;
                    ins_next      = 1'b0;
                    full_next     = 1'b0;
                    accw_next     = '0;
                    sum_next      = '0;
                    pacc_next     = region_start;
                    left_next     = {{(LEFT_W-VALUE_W){column_in[VALUE_W-1]}}, column_in};
                    if (ctrl.req == REQ_CLEAR)
                    begin
                        count_next = '0;
                        total_next = '0;
                    end
                end
            end

            PH_STEP:
            begin
                if (carrying_reg)
                begin
                    // Everything after an insertion moves down by one slot.
                    tail       = carry_reg;
                    carry_next = head;
                end
                else if (!done_reg)
                begin
                    case (req_reg)
                        REQ_ADD:
                        begin
                            if (!ignore_reg)
                            begin
                                if (entry_valid && pos_eq)
                                begin
                                    // Known site: keep the larger width.
                                    if (wnew_reg > head.width)
                                    begin
                                        tail.width = wnew_reg;
                                        total_next = total_reg + TOT_W'(wnew_reg)
                                                   - TOT_W'(head.width);
                                    end
                                    done_next = 1'b1;
                                end
                                else if (!entry_valid || pos_gt)
                                begin
                                    // Insertion point reached.
                                    if (has_room)
                                    begin
                                        tail          = new_site;
                                        carry_next    = head;
                                        carrying_next = 1'b1;
                                        ins_next      = 1'b1;
                                        total_next    = total_reg + TOT_W'(wnew_reg);
                                    end
                                    else
                                    begin
                                        full_next = 1'b1;
                                    end
                                    done_next = 1'b1;
                                end
                            end
                        end

                        REQ_WIDTH:
                        begin
                            if (entry_valid)
                            begin
                                if (pos_eq)
                                begin
                                    accw_next = head.width;
                                    done_next = 1'b1;
                                end
                                else if (pos_gt)
                                begin
                                    done_next = 1'b1;
                                end
                            end
                        end

                        REQ_COLOF:
                        begin
                            if (entry_valid)
                            begin
                                if (pos_gt)
                                begin
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    sum_next = sum_reg + TOT_W'(head.width);
                                end
                            end
                        end

                        REQ_POSOF:
                        begin
                            if (entry_valid)
                            begin
                                if (diff < 0)
                                begin
                                    // Column lies in the plain span before this site.
                                    done_next = 1'b1;
                                end
                                else
                                begin
                                    pacc_next = head.pos;
                                    if (diff < head_w)
                                    begin
                                        // Column falls inside the inserted gap.
                                        left_next = '0;
                                        done_next = 1'b1;
                                    end
                                    else
                                    begin
                                        left_next = diff - head_w;
                                    end
                                end
                            end
                        end

                        default:
                        begin
                        end
                    endcase
                end

                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(SITES - 1))
                begin
                    phase_next = PH_FIN;
                end
            end

            PH_FIN:
            begin
                // Form the answer from what the pass collected.
                count_next  = count_reg + CNT_W'(ins_reg);
                status_next = STATUS_OK;
                case (req_reg)
                    REQ_ADD:
                    begin
                        value_next = '0;
                        if (ignore_reg)
                        begin
                            status_next = STATUS_IGNORED;
                        end
                        else if (full_reg || !done_reg)
                        begin
                            status_next = STATUS_FULL;
                        end
                    end
                    REQ_WIDTH:
                    begin
                        value_next = $signed({{(VALUE_W-WID_W){1'b0}}, accw_reg});
                    end
                    REQ_COLOF:
                    begin
                        value_next = $signed({{(VALUE_W-POS_W){1'b0}}, pos_reg})
                                   - $signed({{(VALUE_W-POS_W){1'b0}}, region_start})
                                   + $signed({{(VALUE_W-TOT_W){1'b0}}, sum_reg});
                    end
                    REQ_POSOF:
                    begin
                        if ((&sum_top) || !(|sum_top))
                        begin
                            value_next = pos_sum[VALUE_W-1:0];
                        end
                        else if (pos_sum[SUM_W-1])
                        begin
                            value_next = {1'b1, {(VALUE_W-1){1'b0}}};
                        end
                        else
                        begin
                            value_next = {1'b0, {(VALUE_W-1){1'b1}}};
                        end
                    end
                    REQ_COUNT:
                    begin
                        value_next = $signed({{(VALUE_W-POS_W){1'b0}}, region_length})
                                   + $signed({{(VALUE_W-TOT_W){1'b0}}, total_reg});
                    end
                    default:
                    begin
                        value_next = '0;
                    end
                endcase
                phase_next = PH_DONE;
            end

            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            total_reg    <= '0;
            done_reg     <= 1'b0;
            carrying_reg <= 1'b0;
            ins_reg      <= 1'b0;
            full_reg     <= 1'b0;
            ignore_reg   <= 1'b0;
            idx_reg      <= '0;
            req_reg      <= REQ_CLEAR;
        end
        else
        begin
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            done_reg     <= done_next;
            carrying_reg <= carrying_next;
            ins_reg      <= ins_next;
            full_reg     <= full_next;
            ignore_reg   <= ignore_next;
            idx_reg      <= idx_next;
            req_reg      <= req_next;
        end
    end

    // Request payload and running sums.
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        wnew_reg   <= wnew_next;
        carry_reg  <= carry_next;
        accw_reg   <= accw_next;
        sum_reg    <= sum_next;
        pacc_reg   <= pacc_next;
        left_reg   <= left_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign stat.shift  = phase_reg == PH_STEP;
    assign stat.finish = phase_reg == PH_DONE;
    assign stat.count  = count_reg;
    assign value       = value_reg;
    assign status      = status_reg;

endmodule

/* rtl/gapped_column_map_table.sv */
// An item is accepted only while idle. The scan unit steps through the whole table,
// finishes, and holds its answer until the output register takes it; the site table
// makes one full turn through its chain of cells past the single scan unit per item.
// A finished result waits in the output register while the next item is accepted.
// Reset (rst_n, asynchronous, active low) empties the table and clears both
// region registers; the site cells themselves are not reset and need no clearing.
`include "gapped_column_map_table_macros.svh"

module gapped_column_map_table
    import gcmt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,

    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [REQ_W-1:0]          req_type,
    input  logic [POS_W-1:0]          ref_pos,
    input  logic [LEN_W-1:0]          ins_length,
    input  logic signed [VALUE_W-1:0] column_in,

    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [VALUE_W-1:0] value,
    output logic [STAT_W-1:0]         status,

    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);

    localparam logic [0:0] ST_IDLE = 1'b0;
    localparam logic [0:0] ST_RUN  = 1'b1;

    localparam logic [0:0] CFG_START  = 1'b0;
    localparam logic [0:0] CFG_LENGTH = 1'b1;

    logic [0:0]                state_reg, state_next;
    logic [POS_W-1:0]          start_reg;
    logic [POS_W-1:0]          length_reg;
    logic                      out_valid_reg, out_valid_next;
    logic signed [VALUE_W-1:0] value_reg;
    logic [STAT_W-1:0]         status_reg;

    logic                      accept;
    logic                      cfg_write;
    logic                      load;
    scan_ctrl_t                ctrl;
    scan_stat_t                stat;
    site_t                     head;
    site_t                     tail;
    site_t                     cell_q [SITES];
    logic signed [VALUE_W-1:0] scan_value;
    logic [STAT_W-1:0]         scan_status;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            length_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                CFG_START:  start_reg  <= pwdata;
                CFG_LENGTH: length_reg <= pwdata;
                default:    start_reg  <= start_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            CFG_START:  prdata = start_reg;
            CFG_LENGTH: prdata = length_reg;
            default:    prdata = '0;
        endcase
    end

    // Input handshake: one item at a time.
    assign in_stall   = state_reg != ST_IDLE;
    assign accept     = in_valid && !in_stall;
    assign ctrl.start = accept;
    assign ctrl.req   = req_type;

    // Move the result into the output register once it is free.
    assign load = (state_reg == ST_RUN) && stat.finish && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            value_reg  <= scan_value;
            status_reg <= scan_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign status    = status_reg;

    // Site table: a ring of cells, read at cell zero and refilled at the far end.
    genvar k;
    generate
        for (k = 0; k < SITES; k++)
        begin : g_cell
            if (k == SITES - 1)
            begin : g_tail
                gcmt_cell u_cell (
                    .clk   (clk),
                    .shift (stat.shift),
                    .din   (tail),
                    .dout  (cell_q[k])
                );
            end
            else
            begin : g_body
                gcmt_cell u_cell (
                    .clk   (clk),
                    .shift (stat.shift),
                    .din   (cell_q[k+1]),
                    .dout  (cell_q[k])
                );
            end
        end
    endgenerate

    assign head = cell_q[0];

    // Scan unit that walks the sorted sites one per cycle.
    gcmt_scan u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .ref_pos       (ref_pos),
        .ins_length    (ins_length),
        .column_in     (column_in),
        .region_start  (start_reg),
        .region_length (length_reg),
        .head          (head),
        .tail          (tail),
        .stat          (stat),
        .value         (scan_value),
        .status        (scan_status)
    );

    // Design checks.
    `GCMT_ASSERT_NEXT(a_accept_busy, accept, in_stall)
    `GCMT_ASSERT_IMPL(a_shift_in_run, stat.shift, state_reg == ST_RUN)
    `GCMT_ASSERT_IMPL(a_count_bound, 1'b1, stat.count <= CNT_W'(SITES))
    `GCMT_ASSERT_NEXT(a_load_shows, load, out_valid)

endmodule
